/* rtl/tdpel_pkg.sv */
// Shared types, constants and helpers for the two-dimensional parity error locator.
package tdpel_pkg;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_CLEAN   = 2'd0,
    STATUS_SINGLE  = 2'd1,
    STATUS_CORRUPT = 2'd2
  } status_t;

  // Odd-line counter saturates at two.
  typedef logic [1:0] odd_cnt_t;
  localparam odd_cnt_t ODD_CNT_SAT = 2'd2;

  // Width of the matrix size register and of the result positions.
  localparam int unsigned SIZE_W = 8;
  localparam int unsigned POS_W  = 8;

  // Control handed from the top level to the column parity chain.
  typedef struct packed {
    logic clear;     // drop all column parities
    logic shift;     // one entry transfer is consumed this cycle
    logic last_row;  // entry belongs to the final row of the matrix
    logic entry;     // low bit of the entry
  } chain_ctrl_t;

  // Saturating increment of an odd-line counter.
  function automatic odd_cnt_t bump_count(input odd_cnt_t cnt);
    bump_count = (cnt == ODD_CNT_SAT) ? ODD_CNT_SAT : odd_cnt_t'(cnt + odd_cnt_t'(1));
  endfunction

endpackage

/* rtl/tdpel_cell.sv */
// One column parity cell of the rotating parity chain.
module tdpel_cell import tdpel_pkg::*; (
  input  logic clk,
  input  logic clear,
  input  logic shift,
  input  logic tail,
  input  logic from_next,
  input  logic feedback,
  output logic parity
);

  // The tail cell takes the updated head value; the others take their neighbor.
  always_ff @(posedge clk) begin
    if (clear) begin
      parity <= 1'b0;
    end else if (shift) begin
      parity <= tail ? feedback : from_next;
    end
  end

endmodule

/* rtl/tdpel_col_chain.sv */
// Rotating chain of column parity cells; the head cell is always the current column.
module tdpel_col_chain import tdpel_pkg::*; #(
  parameter int unsigned MAX_SIDE = 128,
  parameter int unsigned IDX_W    = 7
) (
  input  logic             clk,
  input  logic             rst,
  input  chain_ctrl_t      ctrl,
  input  logic [IDX_W-1:0] side_m1,
  output logic             head_parity
);

  logic [MAX_SIDE-1:0] cell_q;
  logic [MAX_SIDE-1:0] next_in;
  logic                feedback;
  logic                cell_clear;

  // Updated parity of the current column; it is dropped once the last row consumes it.
  assign head_parity = cell_q[0] ^ ctrl.entry;
  assign feedback    = ctrl.last_row ? 1'b0 : head_parity;
  assign cell_clear  = rst | ctrl.clear;

  // Each cell hands its bit toward the head; the tail cell at index side_m1 takes the feedback.
  genvar k;
  generate
    for (k = 0; k < MAX_SIDE; k++) begin : g_cell
      if (k == MAX_SIDE - 1) begin : g_end
        assign next_in[k] = 1'b0;
      end else begin : g_mid
        assign next_in[k] = cell_q[k+1];
      end
      tdpel_cell u_cell (
        .clk       (clk),
        .clear     (cell_clear),
        .shift     (ctrl.shift),
        .tail      (side_m1 == IDX_W'(k)),
        .from_next (next_in[k]),
        .feedback  (feedback),
        .parity    (cell_q[k])
      );
    end
  endgenerate

endmodule

/* rtl/two_dim_parity_error_locator.sv */
// Top level of the two-dimensional parity error locator.
//
// Usage: write matrix_size on the cfg channel (cfg_valid/cfg_ready, ready is
// always high) while the block is idle; a write also abandons any partial
// matrix. Sizes of zero count as one, sizes above MAX_SIDE as MAX_SIDE.
// Entries stream in on entry_bit, one per transfer, row-major order. After
// the final entry of each matrix one result transfer carries check_status,
// error_row and error_col (1-based, zero unless a single bit is correctable).
// Throughput is one entry per cycle while input is not stalled: column
// parities live in a rotating chain of cells whose head is always the
// current column, so every entry is a single shift. The result is registered
// and appears the cycle after the final entry is taken. Input is stalled only
// while a result waits and the receiver stalls. Reset clears all parity state,
// sets the size to one and empties the result register.
module two_dim_parity_error_locator import tdpel_pkg::*; #(
  parameter int unsigned MAX_SIDE = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SIZE_W-1:0] matrix_size,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              entry_bit,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        check_status,
  output logic [POS_W-1:0]  error_row,
  output logic [POS_W-1:0]  error_col
);

  localparam int unsigned IDX_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_SIDE + 1);
  localparam int unsigned EXT_W = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;

  logic [IDX_W-1:0] side_m1;
  logic [IDX_W-1:0] side_m1_next;
  logic [IDX_W-1:0] row_pos;
  logic [IDX_W-1:0] col_pos;
  logic             row_par;
  odd_cnt_t         odd_row_cnt;
  odd_cnt_t         odd_col_cnt;
  logic [IDX_W-1:0] odd_row_idx;
  logic [IDX_W-1:0] odd_col_idx;

  odd_cnt_t         odd_row_cnt_next;
  odd_cnt_t         odd_col_cnt_next;
  logic [IDX_W-1:0] odd_row_idx_next;
  logic [IDX_W-1:0] odd_col_idx_next;
  logic             row_par_upd;
  logic             col_par_upd;

  logic             cfg_write;
  logic             accept;
  logic             last_col;
  logic             last_row;
  logic             final_entry;
  logic [EXT_W-1:0] size_ext;
  logic [EXT_W-1:0] row_num;
  logic [EXT_W-1:0] col_num;
  status_t          status_next;
  chain_ctrl_t      chain_ctrl;

  // Handshakes.
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid & cfg_ready;
  assign in_stall  = out_valid & out_stall;
  assign accept    = in_valid & ~in_stall;

  // Clamp the written size into 1..MAX_SIDE and keep it as side minus one.
  assign size_ext = EXT_W'(matrix_size);
  always_comb begin
    if (size_ext == '0) begin
      side_m1_next = '0;
    end else if (size_ext > EXT_W'(MAX_SIDE)) begin
      side_m1_next = IDX_W'(MAX_SIDE - 1);
    end else begin
      side_m1_next = IDX_W'(size_ext - EXT_W'(1));
    end
  end

  // Position within the matrix.
  assign last_col    = (col_pos == side_m1);
  assign last_row    = (row_pos == side_m1);
  assign final_entry = last_col & last_row;

  // Column parity chain.
  assign chain_ctrl.clear    = cfg_write | (accept & final_entry);
  assign chain_ctrl.shift    = accept;
  assign chain_ctrl.last_row = last_row;
  assign chain_ctrl.entry    = entry_bit;

  tdpel_col_chain #(
    .MAX_SIDE (MAX_SIDE),
    .IDX_W    (IDX_W)
  ) u_chain (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (chain_ctrl),
    .side_m1     (side_m1),
    .head_parity (col_par_upd)
  );

  // Odd row and odd column bookkeeping for the current entry.
  assign row_par_upd = row_par ^ entry_bit;
  always_comb begin
    odd_row_cnt_next = odd_row_cnt;
    odd_row_idx_next = odd_row_idx;
    odd_col_cnt_next = odd_col_cnt;
    odd_col_idx_next = odd_col_idx;
    if (last_col && row_par_upd) begin
      odd_row_cnt_next = bump_count(odd_row_cnt);
      odd_row_idx_next = row_pos;
    end
    if (last_row && col_par_upd) begin
      odd_col_cnt_next = bump_count(odd_col_cnt);
      odd_col_idx_next = col_pos;
    end
  end

  // Verdict for the matrix that ends with this entry.
  always_comb begin
    if (odd_row_cnt_next == odd_cnt_t'(0) && odd_col_cnt_next == odd_cnt_t'(0)) begin
      status_next = STATUS_CLEAN;
    end else if (odd_row_cnt_next == odd_cnt_t'(1) && odd_col_cnt_next == odd_cnt_t'(1)) begin
      status_next = STATUS_SINGLE;
    end else begin
      status_next = STATUS_CORRUPT;
    end
  end

  assign row_num = EXT_W'(odd_row_idx_next) + EXT_W'(1);
  assign col_num = EXT_W'(odd_col_idx_next) + EXT_W'(1);

  // Matrix state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      side_m1     <= '0;
      row_pos     <= '0;
      col_pos     <= '0;
      row_par     <= 1'b0;
      odd_row_cnt <= '0;
      odd_col_cnt <= '0;
      odd_row_idx <= '0;
      odd_col_idx <= '0;
    end else if (cfg_write) begin
      side_m1     <= side_m1_next;
      row_pos     <= '0;
      col_pos     <= '0;
      row_par     <= 1'b0;
      odd_row_cnt <= '0;
      odd_col_cnt <= '0;
      odd_row_idx <= '0;
      odd_col_idx <= '0;
    end else if (accept) begin
      if (final_entry) begin
        row_pos     <= '0;
        col_pos     <= '0;
        row_par     <= 1'b0;
        odd_row_cnt <= '0;
        odd_col_cnt <= '0;
        odd_row_idx <= '0;
        odd_col_idx <= '0;
      end else begin
        odd_row_cnt <= odd_row_cnt_next;
        odd_col_cnt <= odd_col_cnt_next;
        odd_row_idx <= odd_row_idx_next;
        odd_col_idx <= odd_col_idx_next;
        if (last_col) begin
          row_par <= 1'b0;
          col_pos <= '0;
          row_pos <= row_pos + IDX_W'(1);
        end else begin
          row_par <= row_par_upd;
          col_pos <= col_pos + IDX_W'(1);
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && final_entry) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && final_entry) begin
      check_status <= status_next;
      if (status_next == STATUS_SINGLE) begin
        error_row <= row_num[POS_W-1:0];
        error_col <= col_num[POS_W-1:0];
      end else begin
        error_row <= '0;
        error_col <= '0;
      end
    end
  end

endmodule
